### hdl/quaternion_to_euler_assert.svh
// Assertion macros for the quaternion to Euler angle converter.
// Used by the top level; depends on nothing else.
`ifndef QUATERNION_TO_EULER_ASSERT_SVH
`define QUATERNION_TO_EULER_ASSERT_SVH

// Check a consequence in the same cycle as its condition
`define Q2E_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("q2e: same-cycle check failed");

// Check a consequence in the cycle after its condition
`define Q2E_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("q2e: next-cycle check failed");

`endif

### hdl/q2e_pkg.sv
// Shared constants, types and the arctangent table for the quaternion to Euler converter.
// Used by every module of the block; depends on nothing.
package q2e_pkg;

   // Fixed-point formats
   localparam int QUAT_FRAC_BITS  = 14;
   localparam int ANGLE_FRAC_BITS = 12;
   localparam int QUAT_W          = 16;
   localparam int PROD_W          = 2 * QUAT_W;
   localparam int SUM_W           = PROD_W + 3;
   localparam int SIN_W           = 33;
   localparam int SINX_W          = SIN_W + 1;
   localparam int SIN_SCALE       = 31 - 2 * QUAT_FRAC_BITS;
   localparam int ROLL_W          = 15;
   localparam int PITCH_W         = 14;
   localparam int YAW_W           = 15;

   // CORDIC geometry
   localparam int WORD_W        = 64;
   localparam int ZF            = 60;
   localparam int NITER         = 62;
   localparam int NORM_STEPS    = 6;
   localparam int ITER_BASE     = 2 + NORM_STEPS;
   localparam int CORDIC_STAGES = ITER_BASE + NITER;
   localparam int SQRT_STEPS    = WORD_W / 2;
   localparam int ROUND_SHIFT   = ZF - ANGLE_FRAC_BITS;

   // Lanes of the angle unit
   localparam int NLANES     = 3;
   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_YAW   = 2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam logic [QPTR_W:0] QUEUE_FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [NITER-1:0][WORD_W-1:0] atan_tab_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] roll_y;
      logic signed [SUM_W-1:0] roll_x;
      logic signed [SUM_W-1:0] yaw_y;
      logic signed [SUM_W-1:0] yaw_x;
      logic signed [SIN_W-1:0] sin_arg;
      logic                    sat;
   } item_type;

   localparam logic signed [SUM_W-1:0] QUAT_ONE =
      SUM_W'(64'sd1 <<< (2 * QUAT_FRAC_BITS));
   localparam logic signed [SINX_W-1:0] UNIT31 = SINX_W'(64'sd1 <<< 31);
   localparam word_type ROUND_HALF = word_type'(64'sd1 <<< (ROUND_SHIFT - 1));
   localparam logic signed [PITCH_W-1:0] PITCH_LIMIT = 14'sd6434;

   // Restoring long division, elaboration only
   function automatic logic [WORD_W-1:0] udiv(input logic [WORD_W-1:0] num,
                                              input logic [WORD_W-1:0] den);
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] quo;
      rem = '0;
      quo = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         rem = {rem[WORD_W-2:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(1/n) scaled by 2^ZF, by its power series
   function automatic logic [WORD_W-1:0] atan_inv(input logic [WORD_W-1:0] n);
      logic [WORD_W-1:0] p;
      logic [WORD_W-1:0] sum;
      logic [WORD_W-1:0] term;
      logic [WORD_W-1:0] k;
      logic              neg;
      p   = udiv(WORD_W'(1) << ZF, n);
      sum = '0;
      k   = WORD_W'(1);
      neg = 1'b0;
      while (p != '0) begin
         term = udiv(p, k);
         if (neg) sum = sum - term;
         else     sum = sum + term;
         neg = !neg;
         k   = k + WORD_W'(2);
         p   = udiv(udiv(p, n), n);
      end
      return sum;
   endfunction

   function automatic atan_tab_type build_atan_tab();
      atan_tab_type tab;
      tab[0] = WORD_W'(4) * atan_inv(WORD_W'(5)) - atan_inv(WORD_W'(239));
      for (int i = 1; i < NITER; i++) begin
         tab[i] = atan_inv(WORD_W'(1) << i);
      end
      return tab;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan_tab();
   localparam word_type HALF_PI = word_type'({ATAN_TAB[0][WORD_W-2:0], 1'b0});

endpackage

### hdl/q2e_front.sv
// Front end: accepts quaternions, forms the products and the atan2/asin operands.
// Depends on q2e_pkg; feeds q2e_queue.
module q2e_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [q2e_pkg::QUAT_W-1:0]   req_quat_w,
   input  logic signed [q2e_pkg::QUAT_W-1:0]   req_quat_x,
   input  logic signed [q2e_pkg::QUAT_W-1:0]   req_quat_y,
   input  logic signed [q2e_pkg::QUAT_W-1:0]   req_quat_z,
   input  logic                                q_full,
   output logic                                q_push,
   output q2e_pkg::item_type                   q_item
);
   import q2e_pkg::*;

   logic adv;
   logic f1_valid_ff, f2_valid_ff;
   logic signed [PROD_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, zz_ff;
   logic signed [PROD_W-1:0] wz_ff, xy_ff, wy_ff, zx_ff;
   logic signed [SUM_W-1:0]  sin_full, sin_clamp;
   logic                     sin_sat;
   item_type                 item_in, item_ff;

   // Advance unless a finished item is blocked by a full queue
   assign adv      = !(f2_valid_ff && q_full);
   assign req_full = !adv;
   assign q_push   = f2_valid_ff && !q_full;
   assign q_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= req_push;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   // Stage 1: component products
   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         wy_ff <= req_quat_w * req_quat_y;
         zx_ff <= req_quat_z * req_quat_x;
      end
   end

   // Stage 2: operand sums, clamp the sine argument and flag the clamp
   always_comb begin
      sin_full = (SUM_W'(wy_ff) - SUM_W'(zx_ff)) <<< 1;
      sin_sat  = 1'b0;
      sin_clamp = sin_full;
      if (sin_full > QUAT_ONE) begin
         sin_clamp = QUAT_ONE;
         sin_sat   = 1'b1;
      end
      if (sin_full < -QUAT_ONE) begin
         sin_clamp = -QUAT_ONE;
         sin_sat   = 1'b1;
      end
      item_in.roll_y  = (SUM_W'(wx_ff) + SUM_W'(yz_ff)) <<< 1;
      item_in.roll_x  = QUAT_ONE - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
      item_in.yaw_y   = (SUM_W'(wz_ff) + SUM_W'(xy_ff)) <<< 1;
      item_in.yaw_x   = QUAT_ONE - ((SUM_W'(yy_ff) + SUM_W'(zz_ff)) <<< 1);
      item_in.sin_arg = SIN_W'(sin_clamp) <<< SIN_SCALE;
      item_in.sat     = sin_sat;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

endmodule

### hdl/q2e_queue.sv
// Short flop-based queue that decouples the front end from the angle pipeline.
// Depends on q2e_pkg.
module q2e_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  q2e_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output q2e_pkg::item_type pop_item,
   output logic              empty
);
   import q2e_pkg::*;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == QUEUE_FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/q2e_sqrt.sv
// Back end, first part: forms (1-s)(1+s) and its integer square root, one bit pair a stage.
// Depends on q2e_pkg; the operands of the item ride along to the angle pipeline.
module q2e_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  q2e_pkg::item_type              in_item,
   output logic                           out_valid,
   output q2e_pkg::item_type              out_item,
   output logic [q2e_pkg::WORD_W-1:0]     out_root
);
   import q2e_pkg::*;

   logic [SQRT_STEPS:0]    valid_ff;
   item_type               item_ff [SQRT_STEPS+1];
   logic [WORD_W-1:0]      rem_ff  [SQRT_STEPS+1];
   logic [WORD_W-1:0]      root_ff [SQRT_STEPS+1];
   logic signed [SINX_W-1:0] one_minus, one_plus;
   logic [2*SIN_W-1:0]     prod;

   assign one_minus = UNIT31 - SINX_W'(in_item.sin_arg);
   assign one_plus  = UNIT31 + SINX_W'(in_item.sin_arg);
   assign prod      = one_minus[SIN_W-1:0] * one_plus[SIN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[SQRT_STEPS-1:0], in_valid};
      end
   end

   // Stage 0: register the radicand
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= prod[WORD_W-1:0];
         root_ff[0] <= '0;
         item_ff[0] <= in_item;
      end
   end

   // One result bit a stage, from the top bit pair down
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [WORD_W-1:0] BIT = WORD_W'(1) << (WORD_W - 2 - 2 * j);
      logic [WORD_W-1:0] trial;
      assign trial = root_ff[j] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[j+1] <= item_ff[j];
            if (rem_ff[j] >= trial) begin
               rem_ff[j+1]  <= rem_ff[j] - trial;
               root_ff[j+1] <= (root_ff[j] >> 1) + BIT;
            end else begin
               rem_ff[j+1]  <= rem_ff[j];
               root_ff[j+1] <= root_ff[j] >> 1;
            end
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS];
   assign out_item  = item_ff[SQRT_STEPS];
   assign out_root  = root_ff[SQRT_STEPS];

endmodule

### hdl/q2e_cordic.sv
// Back end, second part: three vectoring CORDIC lanes computing atan2 in Q.60 radians.
// Depends on q2e_pkg for the arctangent table and the stage counts.
module q2e_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic              in_tag,
   input  q2e_pkg::word_type in_y [q2e_pkg::NLANES],
   input  q2e_pkg::word_type in_x [q2e_pkg::NLANES],
   output logic              out_valid,
   output logic              out_tag,
   output q2e_pkg::word_type out_angle [q2e_pkg::NLANES]
);
   import q2e_pkg::*;

   localparam int LAST = CORDIC_STAGES - 1;

   logic [CORDIC_STAGES-1:0] valid_ff, tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAST-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff <= {tag_ff[LAST-1:0], in_tag};
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_tag   = tag_ff[LAST];

   for (genvar ln = 0; ln < NLANES; ln++) begin : g_lane
      word_type               x_ff [CORDIC_STAGES];
      word_type               y_ff [CORDIC_STAGES];
      word_type               z_ff [CORDIC_STAGES];
      logic [WORD_W-1:0]      m_ff [1:ITER_BASE-2];
      logic [CORDIC_STAGES-1:0] zero_ff;
      word_type               x_pre, y_pre, z_pre;
      logic [WORD_W-1:0]      ax, ay;

      // Rotate the left half plane into the right one
      always_comb begin
         x_pre = in_x[ln];
         y_pre = in_y[ln];
         z_pre = '0;
         if (in_x[ln] < 0) begin
            if (in_y[ln] >= 0) begin
               x_pre = in_y[ln];
               y_pre = -in_x[ln];
               z_pre = HALF_PI;
            end else begin
               x_pre = -in_y[ln];
               y_pre = in_x[ln];
               z_pre = -HALF_PI;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[0] <= x_pre;
            y_ff[0] <= y_pre;
            z_ff[0] <= z_pre;
            zero_ff <= {zero_ff[LAST-1:0], (in_x[ln] == '0) && (in_y[ln] == '0)};
         end
      end

      // Larger magnitude of the two operands
      assign ax = (x_ff[0] < 0) ? -x_ff[0] : x_ff[0];
      assign ay = (y_ff[0] < 0) ? -y_ff[0] : y_ff[0];

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[1] <= x_ff[0];
            y_ff[1] <= y_ff[0];
            z_ff[1] <= z_ff[0];
            m_ff[1] <= (ax > ay) ? ax : ay;
         end
      end

      // Normalize so the larger magnitude lands in [2^59, 2^60)
      for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
         localparam int SH = (WORD_W / 2) >> k;
         localparam int S  = 1 + k;
         logic grow;
         assign grow = m_ff[S] < (WORD_W'(1) << (ZF - SH));
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[S+1] <= grow ? x_ff[S] <<< SH : x_ff[S];
               y_ff[S+1] <= grow ? y_ff[S] <<< SH : y_ff[S];
               z_ff[S+1] <= z_ff[S];
            end
         end
         if (k < NORM_STEPS - 1) begin : g_mag
            always_ff @(posedge clock) begin
               if (en) begin
                  m_ff[S+1] <= grow ? m_ff[S] << SH : m_ff[S];
               end
            end
         end
      end

      // Micro-rotations driving y toward zero
      for (genvar i = 0; i < NITER; i++) begin : g_iter
         localparam int       S    = ITER_BASE - 1 + i;
         localparam word_type STEP = word_type'(ATAN_TAB[i]);
         always_ff @(posedge clock) begin
            if (en) begin
               if (y_ff[S] > 0) begin
                  x_ff[S+1] <= x_ff[S] + (y_ff[S] >>> i);
                  y_ff[S+1] <= y_ff[S] - (x_ff[S] >>> i);
                  z_ff[S+1] <= z_ff[S] + STEP;
               end else begin
                  x_ff[S+1] <= x_ff[S] - (y_ff[S] >>> i);
                  y_ff[S+1] <= y_ff[S] + (x_ff[S] >>> i);
                  z_ff[S+1] <= z_ff[S] - STEP;
               end
            end
         end
      end

      // Both operands zero give a zero angle
      assign out_angle[ln] = zero_ff[LAST] ? '0 : z_ff[LAST];
   end

endmodule

### hdl/quaternion_to_euler.sv
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg, q2e_front, q2e_queue, q2e_sqrt, q2e_cordic and the assertion header.
//
// Converts one quaternion (Q1.14 components) into roll and yaw in Q2.12 and pitch in Q1.12 radians,
// rounded to nearest, with a flag when the pitch sine argument had to be clamped to +-1.
// One item is accepted every cycle while req_full is low. Each accepted item passes through the
// second front-end stage, the queue, the radicand register and 32 square-root stages, 70 CORDIC
// stages (2 setup, 6 normalization, 62 micro-rotations) and the output register.
// The latency is set by the 62-step CORDIC and the bit-pair square root. While a result
// waits unread the whole back pipeline holds; the front end keeps accepting until its
// four-entry queue fills, and then raises full.
`include "quaternion_to_euler_assert.svh"

module quaternion_to_euler (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [q2e_pkg::QUAT_W-1:0]     req_quat_w,
   input  logic signed [q2e_pkg::QUAT_W-1:0]     req_quat_x,
   input  logic signed [q2e_pkg::QUAT_W-1:0]     req_quat_y,
   input  logic signed [q2e_pkg::QUAT_W-1:0]     req_quat_z,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [q2e_pkg::ROLL_W-1:0]     rsp_roll_angle,
   output logic signed [q2e_pkg::PITCH_W-1:0]    rsp_pitch_angle,
   output logic signed [q2e_pkg::YAW_W-1:0]      rsp_yaw_angle,
   output logic                                  rsp_pitch_saturated
);
   import q2e_pkg::*;

   logic              q_push, q_full, q_pop, q_empty;
   item_type          q_in_item, q_out_item;
   logic              back_en;
   logic              sq_valid;
   item_type          sq_item;
   logic [WORD_W-1:0] sq_root;
   word_type          cd_y [NLANES];
   word_type          cd_x [NLANES];
   word_type          cd_angle [NLANES];
   word_type          rounded [NLANES];
   logic              cd_valid, cd_tag;
   logic              out_valid_ff;
   logic signed [ROLL_W-1:0]  roll_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic signed [YAW_W-1:0]   yaw_ff;
   logic                      sat_ff;
   logic                      pitch_in_range, pitch_at_pole;

   q2e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_quat_w (req_quat_w),
      .req_quat_x (req_quat_x),
      .req_quat_y (req_quat_y),
      .req_quat_z (req_quat_z),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in_item)
   );

   q2e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_out_item),
      .empty     (q_empty)
   );

   // Advance the back pipeline unless an unread result blocks the output
   assign back_en = !out_valid_ff || rsp_pop;
   assign q_pop   = back_en && !q_empty;

   q2e_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (!q_empty),
      .in_item   (q_out_item),
      .out_valid (sq_valid),
      .out_item  (sq_item),
      .out_root  (sq_root)
   );

   // Operand pairs for roll, pitch and yaw
   assign cd_y[LANE_ROLL]  = WORD_W'(sq_item.roll_y);
   assign cd_x[LANE_ROLL]  = WORD_W'(sq_item.roll_x);
   assign cd_y[LANE_PITCH] = WORD_W'(sq_item.sin_arg);
   assign cd_x[LANE_PITCH] = signed'(sq_root);
   assign cd_y[LANE_YAW]   = WORD_W'(sq_item.yaw_y);
   assign cd_x[LANE_YAW]   = WORD_W'(sq_item.yaw_x);

   q2e_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (sq_valid),
      .in_tag    (sq_item.sat),
      .in_y      (cd_y),
      .in_x      (cd_x),
      .out_valid (cd_valid),
      .out_tag   (cd_tag),
      .out_angle (cd_angle)
   );

   // Round to nearest at the output precision
   for (genvar ln = 0; ln < NLANES; ln++) begin : g_round
      assign rounded[ln] = cd_angle[ln] + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (back_en) begin
         out_valid_ff <= cd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         roll_ff  <= rounded[LANE_ROLL][ROUND_SHIFT +: ROLL_W];
         pitch_ff <= rounded[LANE_PITCH][ROUND_SHIFT +: PITCH_W];
         yaw_ff   <= rounded[LANE_YAW][ROUND_SHIFT +: YAW_W];
         sat_ff   <= cd_tag;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_roll_angle      = roll_ff;
   assign rsp_pitch_angle     = pitch_ff;
   assign rsp_yaw_angle       = yaw_ff;
   assign rsp_pitch_saturated = sat_ff;

   // Checks
   assign pitch_in_range = (rsp_pitch_angle <= PITCH_LIMIT) && (rsp_pitch_angle >= -PITCH_LIMIT);
   assign pitch_at_pole  = (rsp_pitch_angle == PITCH_LIMIT) || (rsp_pitch_angle == -PITCH_LIMIT);

   `Q2E_ASSERT_NOW(a_queue_no_overflow, clock, reset, q_full, !q_push)
   `Q2E_ASSERT_NOW(a_pitch_range, clock, reset, !rsp_empty, pitch_in_range)
   `Q2E_ASSERT_NOW(a_sat_at_pole, clock, reset, !rsp_empty && rsp_pitch_saturated, pitch_at_pole)
   `Q2E_ASSERT_NEXT(a_back_holds, clock, reset, !rsp_empty && !rsp_pop, $stable(rsp_pitch_angle) && $stable(cd_valid))

endmodule

### sim/tb.sv
// Self-checking testbench for the quaternion to ZYX Euler angle converter.
// Depends on q2e_pkg and the quaternion_to_euler top level.
`timescale 1ns / 100ps

module tb;
   import q2e_pkg::*;

   localparam int ZFRAC      = 60;
   localparam int STEPS      = 62;
   localparam int NUM_RANDOM = 2000;
   localparam int CYCLE_CAP  = 400000;
   localparam int DRAIN_WAIT = 200;

   typedef struct packed {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [YAW_W-1:0]   yaw;
      logic                      sat;
   } angles_type;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               known;
      angles_type         res;
   } quat_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [15:0] req_quat_w = '0, req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [ROLL_W-1:0]  rsp_roll_angle;
   logic signed [PITCH_W-1:0] rsp_pitch_angle;
   logic signed [YAW_W-1:0]   rsp_yaw_angle;
   logic rsp_pitch_saturated;

   angles_type   angles_due[$];
   quat_row_type quat_rows[$];
   longint       arctan_table[STEPS];
   int           mismatches = 0;
   int           cycles = 0;
   bit           stim_done = 1'b0;
   bit           calm = 1'b0;

   quaternion_to_euler u_top (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // atan(1/n) scaled by 2^60, by its power series
   function automatic longint unsigned arctan_inv(longint unsigned n);
      longint unsigned p, sum, k;
      bit neg;
      p = (64'd1 << ZFRAC) / n;
      sum = 0;
      k = 1;
      neg = 0;
      while (p != 0) begin
         sum = neg ? sum - p / k : sum + p / k;
         neg = !neg;
         k += 2;
         p = p / n / n;
      end
      return sum;
   endfunction

   // vectoring CORDIC, angle in Q.60 radians
   function automatic longint vector_angle(longint yv, longint xv);
      longint zacc, t, dx, dy;
      longint unsigned ax, ay, m;
      int s;
      zacc = 0;
      s = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         t = xv;
         if (yv >= 0) begin
            xv = yv; yv = -t; zacc = 2 * arctan_table[0];
         end else begin
            xv = -yv; yv = t; zacc = -2 * arctan_table[0];
         end
      end
      ax = xv < 0 ? -xv : xv;
      ay = yv < 0 ? -yv : yv;
      m = ax > ay ? ax : ay;
      while (m < (64'd1 << 59)) begin
         m <<= 1;
         s++;
      end
      xv = xv <<< s;
      yv = yv <<< s;
      for (int i = 0; i < STEPS; i++) begin
         dx = yv >>> i;
         dy = xv >>> i;
         if (yv > 0) begin
            xv += dx; yv -= dy; zacc += arctan_table[i];
         end else begin
            xv -= dx; yv += dy; zacc -= arctan_table[i];
         end
      end
      return zacc;
   endfunction

   function automatic longint round_angle(longint zv);
      return (zv + (64'sd1 <<< (ZFRAC - ANGLE_FRAC_BITS - 1))) >>> (ZFRAC - ANGLE_FRAC_BITS);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic angles_type euler_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                               logic signed [15:0] qy, logic signed [15:0] qz);
      longint w, x, y, z, one, u31, ry, rx, yy, yx, s;
      longint unsigned c;
      angles_type a;
      w = qw; x = qx; y = qy; z = qz;
      one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
      u31 = 64'sd1 <<< 31;
      ry = 2 * (w * x + y * z);
      rx = one - 2 * (x * x + y * y);
      yy = 2 * (w * z + x * y);
      yx = one - 2 * (y * y + z * z);
      s = 2 * (w * y - z * x);
      a.sat = 1'b0;
      // clamp the sine argument and flag it
      if (s > one) begin
         s = one; a.sat = 1'b1;
      end
      if (s < -one) begin
         s = -one; a.sat = 1'b1;
      end
      s = s <<< (31 - 2 * QUAT_FRAC_BITS);
      c = int_sqrt(longint'(u31 - s) * longint'(u31 + s));
      a.roll  = ROLL_W'(round_angle(vector_angle(ry, rx)));
      a.pitch = PITCH_W'(round_angle(vector_angle(s, longint'(c))));
      a.yaw   = YAW_W'(round_angle(vector_angle(yy, yx)));
      return a;
   endfunction

   function automatic quat_row_type row(int w, int x, int y, int z, bit known = 0,
                                        int r = 0, int p = 0, int yw = 0, bit st = 0);
      quat_row_type q;
      q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
      q.known = known;
      q.res = '{roll: ROLL_W'(r), pitch: PITCH_W'(p), yaw: YAW_W'(yw), sat: st};
      return q;
   endfunction

   function automatic logic signed [15:0] rand_comp();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 16'($urandom);
      if (k == 1) return 16'((int'($urandom_range(0, 32768)) - 16384) * 2);
      return 16'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   // unit quaternion with random direction, normalized in floating point
   function automatic quat_row_type rand_unit();
      real a, b, c, d, n;
      a = $itor($urandom_range(0, 2000)) - 1000.0;
      b = $itor($urandom_range(0, 2000)) - 1000.0;
      c = $itor($urandom_range(0, 2000)) - 1000.0;
      d = $itor($urandom_range(0, 2000)) - 1000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n == 0.0) return row(16384, 0, 0, 0);
      return row($rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                 $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
   endfunction

   // directed rows, then random ones
   initial begin
      for (int i = 0; i < STEPS; i++)
         arctan_table[i] = (i == 0) ? 4 * arctan_inv(5) - arctan_inv(239)
                                    : arctan_inv(64'd1 << i);
      quat_rows.push_back(row(16384, 0, 0, 0, 1, 0, 0, 0, 0));
      quat_rows.push_back(row(0, 0, 0, 0, 1, 0, 0, 0, 0));
      // zero numerator with negative denominator gives +pi
      quat_rows.push_back(row(0, 16384, 0, 0, 1, 12868, 0, 0, 0));
      quat_rows.push_back(row(0, 0, 0, 16384, 1, 0, 0, 12868, 0));
      quat_rows.push_back(row(11585, 0, 11585, 0));
      quat_rows.push_back(row(11585, 0, -11585, 0));
      quat_rows.push_back(row(16384, 0, 16384, 0));
      quat_rows.push_back(row(-16384, 0, 16384, 0));
      quat_rows.push_back(row(-32768, -32768, -32768, -32768));
      quat_rows.push_back(row(32767, 32767, 32767, 32767));
      quat_rows.push_back(row(32767, -32768, 32767, -32768));
      quat_rows.push_back(row(-32768, 32767, 32767, -32768));
      quat_rows.push_back(row(16384, 16384, 16384, 16384));
      quat_rows.push_back(row(-16384, -16384, -16384, -16384));
      quat_rows.push_back(row(8192, 8192, 8192, 8192));
      quat_rows.push_back(row(-1, -1, -1, -1));
      quat_rows.push_back(row(1, 0, 0, 0));
      quat_rows.push_back(row(11585, 11585, 0, 0));
      quat_rows.push_back(row(11585, 0, 0, -11585));
      quat_rows.push_back(row(-21846, 5461, 10923, -16384));
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if ($urandom_range(0, 2) != 0) quat_rows.push_back(rand_unit());
         else quat_rows.push_back(row(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
      end
   end

   // reset, then feed the quaternions with random bursts of idling
   initial begin
      int gap, idx;
      quat_row_type q;
      idx = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (idx < quat_rows.size()) begin
         q = quat_rows[idx];
         if (!calm && $urandom_range(0, 7) == 0) begin
            req_push <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge clock);
         end
         req_push   <= 1'b1;
         req_quat_w <= q.w;
         req_quat_x <= q.x;
         req_quat_y <= q.y;
         req_quat_z <= q.z;
         @(posedge clock);
         while (req_full) @(posedge clock);
         angles_due.push_back(q.known ? q.res : euler_angles(q.w, q.x, q.y, q.z));
         idx++;
         if (idx > quat_rows.size() - 300) calm = 1'b1;
      end
      req_push <= 1'b0;
      stim_done = 1'b1;
   end

   // pop results with random stalls
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (stall > 0) stall--;
         else if (!calm && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 17);
         rsp_pop <= (stall == 0) && !reset;
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      angles_type got, want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle, rsp_pitch_saturated};
         if (angles_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: %p", got);
         end else begin
            want = angles_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
            end
         end
      end
   end

   // drain, then report; the cycle cap ends a hung run
   initial begin
      while (!(stim_done && angles_due.size() == 0)) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && angles_due.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule

### files.f
+incdir+hdl
hdl/q2e_pkg.sv
hdl/q2e_front.sv
hdl/q2e_queue.sv
hdl/q2e_sqrt.sv
hdl/q2e_cordic.sv
hdl/quaternion_to_euler.sv
sim/tb.sv
